// ----- rtl/lelr_pkg.sv -----
// ----------------------------------------------------------------------------
// lelr_pkg: shared definitions for the line evicting log ring
// Sizes, item kind codes, the controller/datapath command and status bundles,
// and the ring pointer increment.
// ----------------------------------------------------------------------------
package lelr_pkg;

    localparam int DEPTH     = 32768;
    localparam int MAX_READ  = 64;

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int LEN_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 7;
    localparam int STORED_W  = 15;
    localparam int LEFT_W    = $clog2(MAX_READ + 1);
    localparam int CMP_W     = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef enum logic [1:0] {
        KIND_BEGIN  = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_READ   = 2'd2,
        KIND_IGNORE = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic begin_msg;   // latch length, drop any partial message
        logic write_byte;  // store a message byte if one is pending
        logic start_read;  // latch the clamped read count
        logic evict_step;  // drop the oldest byte during eviction
        logic begin_done;  // issue the begin result and settle pending count
        logic emit_byte;   // issue one read result and drop the oldest byte
        logic emit_empty;  // issue an empty read result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic short_free;  // free space is below the declared length
        logic empty;       // no committed bytes
        logic size_one;    // exactly one committed byte
        logic head_nl;     // oldest committed byte is a newline
        logic left_zero;   // read count exhausted
        logic left_one;    // one byte left in the read count
        logic out_free;    // output register can take a result
    } t_status;

    function automatic t_ptr wrap_next(input t_ptr p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

endpackage

// ----- rtl/lelr_ram.sv -----
// ----------------------------------------------------------------------------
// lelr_ram: generic single write port, single read port RAM
// Registered read data; one write and one read per cycle.
// ----------------------------------------------------------------------------
module lelr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lelr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lelr_ctrl: sequencing controller
// Accepts items in idle, runs the eviction scan for begin items and the
// byte-by-byte output of read items.
// ----------------------------------------------------------------------------
module lelr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_kind,
    input  lelr_pkg::t_status  i_status,
    output logic               o_in_stall,
    output lelr_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVICT,
        ST_READ
    } t_state;

    t_state r_state, n_state;
    logic   r_check, n_check;
    logic   r_first, n_first;
    lelr_pkg::t_kind w_kind;

    assign w_kind     = lelr_pkg::t_kind'(i_kind);
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_check = r_check;
        n_first = r_first;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (w_kind)
                        lelr_pkg::KIND_BEGIN: begin
                            o_cmd.begin_msg = 1'b1;
                            n_check         = 1'b1;
                            n_state         = ST_EVICT;
                        end
                        lelr_pkg::KIND_BYTE: begin
                            o_cmd.write_byte = 1'b1;
                        end
                        lelr_pkg::KIND_READ: begin
                            o_cmd.start_read = 1'b1;
                            n_first          = 1'b1;
                            n_state          = ST_READ;
                        end
                        lelr_pkg::KIND_IGNORE: begin
                        end
                    endcase
                end
            end
            ST_EVICT: begin
                // The space test is only made at line boundaries.
                if (r_check && !(i_status.short_free && !i_status.empty)) begin
                    if (i_status.out_free) begin
                        o_cmd.begin_done = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end else begin
                    o_cmd.evict_step = 1'b1;
                    n_check          = i_status.head_nl || i_status.size_one;
                end
            end
            ST_READ: begin
                if (i_status.out_free) begin
                    if (r_first && (i_status.left_zero || i_status.empty)) begin
                        o_cmd.emit_empty = 1'b1;
                        n_state          = ST_IDLE;
                    end else begin
                        o_cmd.emit_byte = 1'b1;
                        n_first         = 1'b0;
                        if (i_status.left_one || i_status.size_one) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_check <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_check <= n_check;
            r_first <= n_first;
        end
    end

endmodule

// ----- rtl/lelr_dp.sv -----
// ----------------------------------------------------------------------------
// lelr_dp: log ring datapath
// Ring pointers, pending count, log store, occupancy arithmetic and the
// output result register.
// ----------------------------------------------------------------------------
module lelr_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lelr_pkg::t_cmd                  i_cmd,
    output lelr_pkg::t_status               o_status,
    input  logic [lelr_pkg::LEN_W-1:0]      i_message_length,
    input  logic [lelr_pkg::BYTE_W-1:0]     i_message_byte,
    input  logic [lelr_pkg::CNT_W-1:0]      i_read_count,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [lelr_pkg::BYTE_W-1:0]     o_read_byte,
    output logic                            o_has_byte,
    output logic [lelr_pkg::LEN_W-1:0]      o_accepted_length,
    output logic [lelr_pkg::STORED_W-1:0]   o_stored_count,
    output logic                            o_last
);

    localparam logic [lelr_pkg::PTR_W:0] DEPTH_X = (lelr_pkg::PTR_W + 1)'(lelr_pkg::DEPTH);

    lelr_pkg::t_ptr r_wp, r_rp, r_fp, n_rp;
    logic [lelr_pkg::LEN_W-1:0]  r_pending;
    logic [lelr_pkg::LEN_W-1:0]  r_len;
    logic [lelr_pkg::LEFT_W-1:0] r_left;

    logic [lelr_pkg::PTR_W:0]    w_diff;
    lelr_pkg::t_ptr              w_size, w_free, w_size_dec;
    logic [lelr_pkg::BYTE_W-1:0] w_rdata;
    logic                        w_we;

    logic                           r_out_valid;
    logic [lelr_pkg::BYTE_W-1:0]    r_read_byte;
    logic                           r_has_byte;
    logic [lelr_pkg::LEN_W-1:0]     r_acc_len;
    logic [lelr_pkg::STORED_W-1:0]  r_stored;
    logic                           r_last;

    always_comb begin
        if (r_rp <= r_wp) begin
            w_diff = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            w_diff = {1'b0, r_wp} + DEPTH_X - {1'b0, r_rp};
        end
    end

    assign w_size     = w_diff[lelr_pkg::PTR_W-1:0];
    assign w_free     = lelr_pkg::PTR_W'(lelr_pkg::DEPTH - 1) - w_size;
    assign w_size_dec = w_size - 1'b1;

    assign w_we = i_cmd.write_byte && (r_pending != '0);
    assign n_rp = (i_cmd.evict_step || i_cmd.emit_byte) ? lelr_pkg::wrap_next(r_rp) : r_rp;

    // The read address follows the next read pointer, so the registered read
    // data always shows the oldest committed byte, at the current read pointer.
    lelr_ram #(
        .WIDTH (lelr_pkg::BYTE_W),
        .DEPTH (lelr_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fp),
        .i_wdata (i_message_byte),
        .i_raddr (n_rp),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_status.short_free = (lelr_pkg::CMP_W'(w_free) < lelr_pkg::CMP_W'(r_len));
        o_status.empty      = (w_size == '0);
        o_status.size_one   = (w_size == lelr_pkg::PTR_W'(1));
        o_status.head_nl    = (w_rdata == lelr_pkg::NEWLINE);
        o_status.left_zero  = (r_left == '0);
        o_status.left_one   = (r_left == lelr_pkg::LEFT_W'(1));
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_fp      <= '0;
            r_pending <= '0;
        end else begin
            r_rp <= n_rp;
            if (i_cmd.begin_msg) begin
                r_fp      <= r_wp;
                r_pending <= '0;
            end
            if (w_we) begin
                r_fp      <= lelr_pkg::wrap_next(r_fp);
                r_pending <= r_pending - 1'b1;
                if (r_pending == lelr_pkg::LEN_W'(1)) begin
                    r_wp <= lelr_pkg::wrap_next(r_fp);
                end
            end
            if (i_cmd.begin_done) begin
                r_pending <= o_status.short_free ? '0 : r_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_msg) begin
            r_len <= i_message_length;
        end
        if (i_cmd.start_read) begin
            if (i_read_count > lelr_pkg::CNT_W'(lelr_pkg::MAX_READ)) begin
                r_left <= lelr_pkg::LEFT_W'(lelr_pkg::MAX_READ);
            end else begin
                r_left <= lelr_pkg::LEFT_W'(i_read_count);
            end
        end else if (i_cmd.emit_byte) begin
            r_left <= r_left - 1'b1;
        end
    end

    // Output result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.begin_done || i_cmd.emit_byte || i_cmd.emit_empty) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_done) begin
            r_read_byte <= '0;
            r_has_byte  <= 1'b0;
            r_acc_len   <= o_status.short_free ? '0 : r_len;
            r_stored    <= lelr_pkg::STORED_W'(w_size);
            r_last      <= 1'b1;
        end else if (i_cmd.emit_empty) begin
            r_read_byte <= '0;
            r_has_byte  <= 1'b0;
            r_acc_len   <= '0;
            r_stored    <= lelr_pkg::STORED_W'(w_size);
            r_last      <= 1'b1;
        end else if (i_cmd.emit_byte) begin
            r_read_byte <= w_rdata;
            r_has_byte  <= 1'b1;
            r_acc_len   <= '0;
            r_stored    <= lelr_pkg::STORED_W'(w_size_dec);
            r_last      <= o_status.left_one || o_status.size_one;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_read_byte       = r_read_byte;
    assign o_has_byte        = r_has_byte;
    assign o_accepted_length = r_acc_len;
    assign o_stored_count    = r_stored;
    assign o_last            = r_last;

endmodule

// ----- rtl/line_evicting_log_ring.sv -----
// ----------------------------------------------------------------------------
// line_evicting_log_ring: byte log ring that evicts whole oldest lines
// Stores messages of declared length, dropping complete oldest lines to make
// room, and hands out the oldest bytes on read requests.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+--------------------------------
//  in      | input     | i_in_valid / o_in_stall | kind, message_length,
//          |           |                         | message_byte, read_count
//  out     | output    | o_out_valid/i_out_stall | read_byte, has_byte,
//          |           |                         | accepted_length, stored_count, last
//
//  Byte transactions and ignored kinds are taken back to back, without a stall.
//  A begin transaction drops oldest bytes by eviction, then issues its result;
//  the scan walks the log store one entry per cycle.
//  A read transaction issues its results in turn, each result
//  leaving through the single output register; output stalls hold it back.
//  Reset is synchronous and active low; the log store needs no clearing.
//
module line_evicting_log_ring (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_kind,
    input  logic [lelr_pkg::LEN_W-1:0]      i_message_length,
    input  logic [lelr_pkg::BYTE_W-1:0]     i_message_byte,
    input  logic [lelr_pkg::CNT_W-1:0]      i_read_count,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [lelr_pkg::BYTE_W-1:0]     o_read_byte,
    output logic                            o_has_byte,
    output logic [lelr_pkg::LEN_W-1:0]      o_accepted_length,
    output logic [lelr_pkg::STORED_W-1:0]   o_stored_count,
    output logic                            o_last
);

    // The controller only issues commands; every pointer, count and byte
    // lives in the datapath. Status comes back as one bundle.
    lelr_pkg::t_cmd    w_cmd;
    lelr_pkg::t_status w_status;

    // The controller sequences each transaction. Begin transactions run an
    // eviction scan that drops one oldest byte per cycle and checks the free
    // space again only after a newline or when one byte was left.
    lelr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the ring pointers, the pending message count, the
    // log store memory and the output register. Message bytes are written at
    // the fill pointer and only become readable when the write pointer jumps
    // to the fill pointer on the final byte of the message.
    lelr_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_message_length  (i_message_length),
        .i_message_byte    (i_message_byte),
        .i_read_count      (i_read_count),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_read_byte       (o_read_byte),
        .o_has_byte        (o_has_byte),
        .o_accepted_length (o_accepted_length),
        .o_stored_count    (o_stored_count),
        .o_last            (o_last)
    );

endmodule

// ----- rtl/lelr_checker.sv -----
// ----------------------------------------------------------------------------
// lelr_checker: port-level assertions for the line evicting log ring
// Watches the top-level ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
module lelr_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [lelr_pkg::BYTE_W-1:0]     o_read_byte,
    input  logic                            o_has_byte,
    input  logic [lelr_pkg::LEN_W-1:0]      o_accepted_length,
    input  logic [lelr_pkg::STORED_W-1:0]   o_stored_count,
    input  logic                            o_last
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_read_byte)
            && $stable(o_has_byte) && $stable(o_accepted_length)
            && $stable(o_stored_count) && $stable(o_last)))
        else $error("stalled result changed");

    // Begin results and empty reads are always the final result.
    a_no_byte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_byte) |-> o_last)
        else $error("result without a byte is not marked last");

    // While a read result that is not the final one waits in the output
    // register, the read is still running and no new transaction is taken.
    a_busy_mid_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_in_stall)
        else $error("input taken in the middle of a read");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind line_evicting_log_ring lelr_checker u_lelr_checker (.*);
